@@ rtl/core/rrsl_pkg.sv @@
// ----------------------------------------------------------------------------
// rrsl_pkg: shared types and constants for the register range lookup
// Table geometry, entry layout, opcodes and result status codes.
// ----------------------------------------------------------------------------
package rrsl_pkg;

	// number of table entries (1 .. 32)
	localparam int NUM_RANGES = 32;
	// bits needed to address one table entry
	localparam int IDX_W = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;

	localparam int ADDR_W  = 16;
	localparam int SUM_W   = ADDR_W + 1;
	localparam int SLAVE_W = 5;

	// one table entry as stored in the RAM
	typedef struct packed {
		logic [15:0] start;
		logic [15:0] length;
		logic [7:0]  device;
		logic [7:0]  iface;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_MATCH = 2'd1,
		ST_OVERHANG = 2'd2
	} status_t;

endpackage

@@ rtl/core/rrsl_ram.sv @@
// ----------------------------------------------------------------------------
// rrsl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module rrsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/register_range_to_slave_lookup_core.sv @@
// ----------------------------------------------------------------------------
// register_range_to_slave_lookup_core: first-match register range lookup
// Stores register ranges in a table and resolves a lookup to the interface and
// index of the first enabled range that holds the requested start address.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | opcode, entry_index, entry_start,
//           |                      | entry_length, entry_device, entry_iface,
//           |                      | query_start, query_length
//   out     | out_valid / out_ready| status, target_iface, slave_index
//
// A write beat is accepted, then its result is presented.
// A lookup beat is accepted with the first read, then scans one table entry per
// cycle through the single RAM read port and the one range comparator, then
// checks for overhang and presents the result. The scan stops at the first hit.
// Reset clears the per-entry valid bits at once, so every entry reads as
// unused; no clearing pass. in_ready is high only while idle; a new beat is
// taken while the previous result still waits in the output register, and
// a finished result holds in the sequencer until that register is free.
// ----------------------------------------------------------------------------
module register_range_to_slave_lookup_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [4:0]  entry_index,
	input  logic [15:0] entry_start,
	input  logic [15:0] entry_length,
	input  logic [7:0]  entry_device,
	input  logic [7:0]  entry_iface,
	input  logic [15:0] query_start,
	input  logic [15:0] query_length,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  target_iface,
	output logic [4:0]  slave_index
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_CHECK,
		S_RESP
	} state_t;

	localparam logic [rrsl_pkg::IDX_W-1:0] LAST_IDX =
		rrsl_pkg::IDX_W'(rrsl_pkg::NUM_RANGES - 1);

	state_t                          state_q;
	logic [rrsl_pkg::IDX_W-1:0]      scan_idx_q;   // index of the entry on rd_data
	logic [rrsl_pkg::NUM_RANGES-1:0] vld_q;        // entry written since reset
	logic [rrsl_pkg::ADDR_W-1:0]     qs_q;         // query start
	logic [rrsl_pkg::SUM_W-1:0]      qend_q;       // query start + length
	logic [rrsl_pkg::SUM_W-1:0]      end_q;        // matched range end
	logic [7:0]                      hit_iface_q;
	rrsl_pkg::status_t               res_status_q;
	logic [7:0]                      res_iface_q;
	logic [4:0]                      res_idx_q;
	logic                            out_valid_q;
	rrsl_pkg::status_t               status_q;
	logic [7:0]                      target_iface_q;
	logic [4:0]                      slave_index_q;

	logic                            accept;
	logic                            wr_en;
	logic [rrsl_pkg::IDX_W-1:0]      wr_addr;
	rrsl_pkg::entry_t                wr_entry;
	logic                            rd_en;
	logic [rrsl_pkg::IDX_W-1:0]      rd_addr;
	logic [rrsl_pkg::ENTRY_W-1:0]    rd_data;
	rrsl_pkg::entry_t                rd_entry;
	logic                            ent_used;
	logic [rrsl_pkg::SUM_W-1:0]      ent_end;
	logic                            hit;
	logic                            out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Write port: drop writes aimed past the end of the table.
	assign wr_en = accept && (opcode == rrsl_pkg::OP_WRITE) &&
		(32'(entry_index) < 32'(rrsl_pkg::NUM_RANGES));
	assign wr_addr  = rrsl_pkg::IDX_W'(entry_index);
	assign wr_entry = '{start: entry_start, length: entry_length,
		device: entry_device, iface: entry_iface};

	// Read port: entry 0 on accept, then the entry after the one being compared.
	assign rd_en   = (accept && (opcode == rrsl_pkg::OP_LOOKUP)) || (state_q == S_SCAN);
	assign rd_addr = (state_q == S_IDLE) ? '0 :
		rrsl_pkg::IDX_W'(scan_idx_q + rrsl_pkg::IDX_W'(1));

	rrsl_ram #(
		.WIDTH (rrsl_pkg::ENTRY_W),
		.DEPTH (rrsl_pkg::NUM_RANGES),
		.AW    (rrsl_pkg::IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_entry = rrsl_pkg::entry_t'(rd_data);

	// Shared range comparator: one entry per cycle. An entry never written,
	// or with zero length or zero device, is skipped.
	assign ent_used = vld_q[scan_idx_q] && (rd_entry.length != '0) &&
		(rd_entry.device != '0);
	assign ent_end  = rrsl_pkg::SUM_W'(rd_entry.start) + rrsl_pkg::SUM_W'(rd_entry.length);
	assign hit      = ent_used && (qs_q >= rd_entry.start) &&
		(rrsl_pkg::SUM_W'(qs_q) < ent_end);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			scan_idx_q     <= '0;
			vld_q          <= '0;
			qs_q           <= '0;
			qend_q         <= '0;
			end_q          <= '0;
			hit_iface_q    <= '0;
			res_status_q   <= rrsl_pkg::ST_OK;
			res_iface_q    <= '0;
			res_idx_q      <= '0;
			out_valid_q    <= 1'b0;
			status_q       <= rrsl_pkg::ST_OK;
			target_iface_q <= '0;
			slave_index_q  <= '0;
		end else begin
			// retire the presented result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == rrsl_pkg::OP_LOOKUP) begin
							qs_q       <= query_start;
							qend_q     <= rrsl_pkg::SUM_W'(query_start) +
								rrsl_pkg::SUM_W'(query_length);
							scan_idx_q <= '0;
							state_q    <= S_SCAN;
						end else begin
							res_status_q <= rrsl_pkg::ST_OK;
							res_iface_q  <= '0;
							res_idx_q    <= '0;
							state_q      <= S_RESP;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						// hold scan_idx_q as the matched index
						end_q       <= ent_end;
						hit_iface_q <= rd_entry.iface;
						state_q     <= S_CHECK;
					end else if (scan_idx_q == LAST_IDX) begin
						res_status_q <= rrsl_pkg::ST_NO_MATCH;
						res_iface_q  <= '0;
						res_idx_q    <= '0;
						state_q      <= S_RESP;
					end else begin
						scan_idx_q <= rrsl_pkg::IDX_W'(scan_idx_q + rrsl_pkg::IDX_W'(1));
					end
				end
				S_CHECK: begin
					if (end_q < qend_q) begin
						res_status_q <= rrsl_pkg::ST_OVERHANG;
						res_iface_q  <= '0;
						res_idx_q    <= '0;
					end else begin
						res_status_q <= rrsl_pkg::ST_OK;
						res_iface_q  <= hit_iface_q;
						res_idx_q    <= rrsl_pkg::SLAVE_W'(scan_idx_q);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					// advance only when the output register is free
					if (out_free) begin
						out_valid_q    <= 1'b1;
						status_q       <= res_status_q;
						target_iface_q <= res_iface_q;
						slave_index_q  <= res_idx_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign target_iface = target_iface_q;
	assign slave_index  = slave_index_q;

endmodule

@@ rtl/core/rrsl_checker.sv @@
// ----------------------------------------------------------------------------
// rrsl_checker: port-level assertions for the register range lookup
// Watches the top-level ports only and is attached by bind.
// ----------------------------------------------------------------------------
module rrsl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [7:0]  target_iface,
	input logic [4:0]  slave_index
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(target_iface) && $stable(slave_index))
		else $error("result beat changed while stalled");

	// one beat in work at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous beat in work");

	// failed lookups carry no target
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rrsl_pkg::ST_NO_MATCH || status == rrsl_pkg::ST_OVERHANG)
		|-> target_iface == 8'd0 && slave_index == 5'd0)
		else $error("failed lookup with nonzero target");

	// only defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == rrsl_pkg::ST_OK || status == rrsl_pkg::ST_NO_MATCH ||
		status == rrsl_pkg::ST_OVERHANG)
		else $error("undefined status code");

	// a write answers with an OK status and a zero target
	a_write_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == rrsl_pkg::OP_WRITE && (!out_valid || out_ready)
		|=> ##1 out_valid && status == rrsl_pkg::ST_OK && target_iface == 8'd0)
		else $error("write result missing or wrong");

endmodule

bind register_range_to_slave_lookup_core rrsl_checker u_rrsl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.opcode       (opcode),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.target_iface (target_iface),
	.slave_index  (slave_index)
);

@@ sim/tb_register_range_to_slave_lookup_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_register_range_to_slave_lookup_core: range table write and lookup check
// Drives table writes and lookups through the valid/ready input channel with
// random idle gaps and output stalls. A shadow range table predicts every
// answer, and each output beat is compared in order against the prediction.
// ----------------------------------------------------------------------------
package rrsl_check_pkg;

	// one input beat as the driver builds it
	typedef struct packed {
		logic        opcode;
		logic [4:0]  index;
		logic [15:0] e_start;
		logic [15:0] e_length;
		logic [7:0]  e_device;
		logic [7:0]  e_iface;
		logic [15:0] q_start;
		logic [15:0] q_length;
	} req_beat_t;

	// one answer as the block presents it
	typedef struct packed {
		rrsl_pkg::status_t status;
		logic [7:0]        iface;
		logic [4:0]        slave;
	} answer_t;

	class range_lookup_board;
		rrsl_pkg::entry_t range_copy [rrsl_pkg::NUM_RANGES];
		answer_t          pending_answers [$];
		int               errors;

		function new();
			foreach (range_copy[i]) range_copy[i] = '0;
			errors = 0;
		endfunction

		// Update the shadow table and queue the answer the block owes.
		function void note_request(req_beat_t b);
			answer_t    a;
			logic [16:0] lim;
			bit          found;
			int          hit;
			a.status = rrsl_pkg::ST_OK;
			a.iface  = '0;
			a.slave  = '0;
			found    = 1'b0;
			hit      = 0;
			if (b.opcode == rrsl_pkg::OP_WRITE) begin
				if (int'(b.index) < rrsl_pkg::NUM_RANGES) begin
					range_copy[b.index].start  = b.e_start;
					range_copy[b.index].length = b.e_length;
					range_copy[b.index].device = b.e_device;
					range_copy[b.index].iface  = b.e_iface;
				end
			end else begin
				for (int i = 0; i < rrsl_pkg::NUM_RANGES; i++) begin
					if (range_copy[i].length == '0 || range_copy[i].device == '0) continue;
					lim = {1'b0, range_copy[i].start} + {1'b0, range_copy[i].length};
					if (b.q_start >= range_copy[i].start && {1'b0, b.q_start} < lim) begin
						found = 1'b1;
						hit   = i;
						break;
					end
				end
				if (!found) begin
					a.status = rrsl_pkg::ST_NO_MATCH;
				end else begin
					lim = {1'b0, range_copy[hit].start} + {1'b0, range_copy[hit].length};
					if (lim < {1'b0, b.q_start} + {1'b0, b.q_length}) begin
						a.status = rrsl_pkg::ST_OVERHANG;
					end else begin
						a.iface = range_copy[hit].iface;
						a.slave = hit[4:0];
					end
				end
			end
			pending_answers.push_back(a);
		endfunction

		// Compare one output beat with the oldest owed answer.
		function void check_answer(logic [1:0] st, logic [7:0] ifc, logic [4:0] si);
			answer_t a;
			if (pending_answers.size() == 0) begin
				$error("unexpected answer: status %0d iface %0d slave_index %0d", st, ifc, si);
				errors++;
				return;
			end
			a = pending_answers.pop_front();
			if (st !== a.status) begin
				$error("status: expected %0d, got %0d", a.status, st);
				errors++;
			end
			if (ifc !== a.iface) begin
				$error("target_iface: expected %0d, got %0d", a.iface, ifc);
				errors++;
			end
			if (si !== a.slave) begin
				$error("slave_index: expected %0d, got %0d", a.slave, si);
				errors++;
			end
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction
	endclass

endpackage

module tb_register_range_to_slave_lookup_core;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = rrsl_pkg::OP_WRITE;
	logic [4:0]  entry_index = '0;
	logic [15:0] entry_start = '0;
	logic [15:0] entry_length = '0;
	logic [7:0]  entry_device = '0;
	logic [7:0]  entry_iface = '0;
	logic [15:0] query_start = '0;
	logic [15:0] query_length = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  target_iface;
	logic [4:0]  slave_index;

	// percentage of idle cycles on each side; zero during the calm stretch
	int idle_pct = 20;

	rrsl_check_pkg::range_lookup_board board = new();

	register_range_to_slave_lookup_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.entry_index  (entry_index),
		.entry_start  (entry_start),
		.entry_length (entry_length),
		.entry_device (entry_device),
		.entry_iface  (entry_iface),
		.query_start  (query_start),
		.query_length (query_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.target_iface (target_iface),
		.slave_index  (slave_index)
	);

	// 12 ns clock
	initial begin
		forever #6 clk = ~clk;
	end

	// Stall the output side at random; a fresh draw every cycle puts the
	// stalls on every phase of the scan, including the held-result case.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= idle_pct);
	end

	// Monitor both channels on the same edge the block samples them. Note the
	// input beat first so a same-edge answer can never outrun its request.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			board.note_request('{opcode, entry_index, entry_start, entry_length,
				entry_device, entry_iface, query_start, query_length});
		end
		if (arst_n && out_valid && out_ready) begin
			board.check_answer(status, target_iface, slave_index);
		end
	end

	// Present one beat and hold it until accepted. Valid drops only when an
	// idle gap is taken, so back-to-back beats never see valid pulse low.
	task automatic send_beat(input rrsl_check_pkg::req_beat_t b);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= b.opcode;
		entry_index  <= b.index;
		entry_start  <= b.e_start;
		entry_length <= b.e_length;
		entry_device <= b.e_device;
		entry_iface  <= b.e_iface;
		query_start  <= b.q_start;
		query_length <= b.q_length;
		do @(posedge clk); while (!in_ready);
	endtask

	// Store one range; the query fields carry random filler.
	task automatic write_range(input logic [4:0] idx, input logic [15:0] st,
			input logic [15:0] ln, input logic [7:0] dev, input logic [7:0] ifc);
		rrsl_check_pkg::req_beat_t b;
		b.opcode   = rrsl_pkg::OP_WRITE;
		b.index    = idx;
		b.e_start  = st;
		b.e_length = ln;
		b.e_device = dev;
		b.e_iface  = ifc;
		b.q_start  = 16'($urandom);
		b.q_length = 16'($urandom);
		send_beat(b);
	endtask

	// Look up one request; the entry fields carry random filler.
	task automatic lookup_range(input logic [15:0] qs, input logic [15:0] ql);
		rrsl_check_pkg::req_beat_t b;
		b.opcode   = rrsl_pkg::OP_LOOKUP;
		b.index    = 5'($urandom);
		b.e_start  = 16'($urandom);
		b.e_length = 16'($urandom);
		b.e_device = 8'($urandom_range(0, 247));
		b.e_iface  = 8'($urandom);
		b.q_start  = qs;
		b.q_length = ql;
		send_beat(b);
	endtask

	initial begin
		int               n;
		int               k;
		rrsl_pkg::entry_t ent;
		logic [16:0]      lim;
		logic [15:0]      qs;
		logic [15:0]      ql;
		logic [15:0]      st;
		logic [15:0]      ln;
		logic [7:0]       dev;

		// hold reset, then release it on an edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// empty table: nothing matches, at both address extremes
		lookup_range(16'h0000, 16'h0000);
		lookup_range(16'hffff, 16'hffff);
		// a plain range at the lowest slot
		write_range(5'd0, 16'h0010, 16'h0010, 8'd1, 8'ha5);
		lookup_range(16'h0012, 16'h0004);
		// ranges at the top of the address space that reach past 65535
		write_range(5'd31, 16'hfff0, 16'hffff, 8'd247, 8'hff);
		write_range(5'd30, 16'hffff, 16'hffff, 8'd247, 8'h00);
		// lowest index wins where both top ranges hold the address
		lookup_range(16'hffff, 16'h0001);
		lookup_range(16'hfff5, 16'hfffa);
		lookup_range(16'hfff5, 16'hfffb);
		// skip entries with zero length or zero device ahead of a live one
		write_range(5'd5, 16'h1000, 16'h0000, 8'd5, 8'h55);
		write_range(5'd6, 16'h1000, 16'h0100, 8'd0, 8'h66);
		write_range(5'd7, 16'h1000, 16'h0100, 8'd9, 8'h77);
		lookup_range(16'h1000, 16'h0010);
		lookup_range(16'h0fff, 16'h0001);
		lookup_range(16'h10ff, 16'h0001);
		lookup_range(16'h1100, 16'h0000);
		// overlapping range at a higher index; slot 0 still wins where both hold
		write_range(5'd3, 16'h0000, 16'h0020, 8'd2, 8'h33);
		lookup_range(16'h0015, 16'h0001);
		lookup_range(16'h0000, 16'h0000);
		// exact fit at the range end, then one past it
		lookup_range(16'h001f, 16'h0001);
		lookup_range(16'h001f, 16'h0002);
		lookup_range(16'h0020, 16'h0001);
		// zero length request never overhangs
		lookup_range(16'h10ff, 16'h0000);

		// ---- random part ----
		for (n = 0; n < 650; n++) begin
			// calm stretch with no idling on either side
			idle_pct = (n >= 250 && n < 400) ? 0 : 20;
			k = $urandom_range(0, rrsl_pkg::NUM_RANGES - 1);
			if ($urandom_range(0, 99) < 35) begin
				// cluster most ranges low so lookups find overlaps
				st = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 16'h03ff))
					: 16'($urandom);
				case ($urandom_range(0, 9))
					0: ln = '0;
					1: ln = 16'($urandom);
					default: ln = 16'($urandom_range(1, 16'h0200));
				endcase
				dev = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 247));
				write_range(k[4:0], st, ln, dev, 8'($urandom));
			end else begin
				// aim at a known entry, its edges, or anywhere
				ent = board.range_copy[k];
				lim = {1'b0, ent.start} + {1'b0, ent.length};
				case ($urandom_range(0, 9))
					0, 1, 2, 3: qs = ent.start + 16'($urandom_range(0, ent.length));
					4: qs = lim[15:0] - 16'd1;
					5: qs = lim[15:0];
					6: qs = ent.start - 16'd1;
					7: qs = 16'($urandom);
					default: qs = 16'($urandom_range(0, 16'h05ff));
				endcase
				case ($urandom_range(0, 9))
					0: ql = '0;
					1: ql = 16'($urandom);
					2: ql = 16'(lim - {1'b0, qs});
					3: ql = 16'(lim - {1'b0, qs}) + 16'd1;
					default: ql = 16'($urandom_range(1, 16'h0100));
				endcase
				lookup_range(qs, ql);
			end
		end
		in_valid <= 1'b0;
		idle_pct = 20;

		// drain: wait for every owed answer, then a full scan's worth more
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (board.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
